FILE: hw/rtl/drbl_pkg.sv
// Shared types, constants and register codes for the DRAM row buffer latency block.
package drbl_pkg;

  localparam int BANKS      = 16;
  localparam int BANK_BITS  = $clog2(BANKS);
  localparam int ROW_BITS   = 18;
  localparam int ROW_SHIFT  = 8;
  localparam int ADDR_W     = 26;
  localparam int DELAY_W    = 8;
  localparam int LAT_W      = 10;
  localparam int OUTCOME_W  = 2;
  localparam int PHASE_W    = 2;
  localparam int COUNT_W    = 32;
  localparam int SUM_W      = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  // register indexes (paddr[3:2])
  localparam logic [REG_IDX_W-1:0] REG_PAGE_POLICY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_DELAY  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_DELAY = 2'd2;

  localparam logic [DELAY_W-1:0] BASE_DELAY_RST  = 8'd10;
  localparam logic [DELAY_W-1:0] PHASE_DELAY_RST = 8'd45;

  // access outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_EMPTY    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_HIT      = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_CONFLICT = 2'd2;

  // phase counts
  localparam logic [PHASE_W-1:0] PH_ONE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TWO   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_THREE = 2'd3;

  typedef struct packed {
    logic               page_policy;
    logic [DELAY_W-1:0] base_delay;
    logic [DELAY_W-1:0] phase_delay;
  } drbl_cfg_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [PHASE_W-1:0]   phases;
    logic                 is_write;
  } drbl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drbl_q_stat_t;

endpackage

FILE: hw/rtl/drbl_in_if.sv
// Access request channel.
interface drbl_in_if import drbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] line_addr;
  logic              is_write;

  modport source (output valid, output line_addr, output is_write, input ready);
  modport sink   (input valid, input line_addr, input is_write, output ready);
endinterface

FILE: hw/rtl/drbl_out_if.sv
// Access result channel.
interface drbl_out_if import drbl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LAT_W-1:0]     latency;
  logic [OUTCOME_W-1:0] outcome;
  logic [COUNT_W-1:0]   kind_count;
  logic [SUM_W-1:0]     kind_delay_total;

  modport source (output valid, output latency, output outcome, output kind_count,
                  output kind_delay_total, input ready);
  modport sink   (input valid, input latency, input outcome, input kind_count,
                  input kind_delay_total, output ready);
endinterface

FILE: hw/rtl/drbl_front.sv
// Front end: accepts accesses, looks up the bank's open row and classifies the access.
module drbl_front import drbl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             page_policy,
  drbl_in_if.sink          req,
  input  drbl_q_stat_t     q_stat,
  output logic             push,
  output drbl_cmd_t        push_cmd
);

  logic [ROW_BITS-1:0]  open_row [BANKS];
  logic [BANKS-1:0]     row_valid;
  logic [BANK_BITS-1:0] bank;
  logic [ROW_BITS-1:0]  row;

  assign bank      = req.line_addr[BANK_BITS-1:0];
  assign row       = req.line_addr[ROW_SHIFT +: ROW_BITS];
  assign req.ready = !q_stat.full;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_cmd.is_write = req.is_write;
    if (!row_valid[bank]) begin
      push_cmd.outcome = OUT_EMPTY;
      push_cmd.phases  = PH_TWO;
    end else if (open_row[bank] == row) begin
      push_cmd.outcome = OUT_HIT;
      push_cmd.phases  = page_policy ? PH_TWO : PH_ONE;
    end else begin
      push_cmd.outcome = OUT_CONFLICT;
      push_cmd.phases  = page_policy ? PH_TWO : PH_THREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (push) begin
      row_valid[bank] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      open_row[bank] <= row;
    end
  end

endmodule

FILE: hw/rtl/drbl_cmd_fifo.sv
// Short queue of classified accesses between front and back end.
module drbl_cmd_fifo import drbl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  drbl_cmd_t    push_cmd,
  input  logic         pop,
  output drbl_cmd_t    pop_cmd,
  output drbl_q_stat_t stat
);

  drbl_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/drbl_back.sv
// Back end: computes latency, updates per-kind statistics and holds the result register.
module drbl_back import drbl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  drbl_cfg_t    cfg,
  input  drbl_cmd_t    cmd,
  input  drbl_q_stat_t q_stat,
  output logic         pop,
  drbl_out_if.source   rsp
);

  logic                 out_valid;
  logic [LAT_W-1:0]     out_latency;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [COUNT_W-1:0]   out_count;
  logic [SUM_W-1:0]     out_sum;

  logic [COUNT_W-1:0]   read_count;
  logic [COUNT_W-1:0]   write_count;
  logic [SUM_W-1:0]     read_delay_sum;
  logic [SUM_W-1:0]     write_delay_sum;

  logic [LAT_W-1:0]     latency;
  logic [COUNT_W-1:0]   cnt_cur;
  logic [SUM_W-1:0]     sum_cur;
  logic [COUNT_W-1:0]   cnt_next;
  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     sum_next;

  assign pop = !q_stat.empty && (!out_valid || rsp.ready);

  always_comb begin
    latency  = LAT_W'(cfg.base_delay) + LAT_W'(cmd.phases) * LAT_W'(cfg.phase_delay);
    cnt_cur  = cmd.is_write ? write_count : read_count;
    sum_cur  = cmd.is_write ? write_delay_sum : read_delay_sum;
    cnt_next = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
    sum_wide = {1'b0, sum_cur} + (SUM_W + 1)'(latency);
    // carry out means the total passed its all-ones ceiling
    sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      read_count      <= '0;
      write_count     <= '0;
      read_delay_sum  <= '0;
      write_delay_sum <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (cmd.is_write) begin
          write_count     <= cnt_next;
          write_delay_sum <= sum_next;
        end else begin
          read_count     <= cnt_next;
          read_delay_sum <= sum_next;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_latency <= latency;
      out_outcome <= cmd.outcome;
      out_count   <= cnt_next;
      out_sum     <= sum_next;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.latency          = out_latency;
  assign rsp.outcome          = out_outcome;
  assign rsp.kind_count       = out_count;
  assign rsp.kind_delay_total = out_sum;

endmodule

FILE: hw/rtl/dram_row_buffer_latency.sv
// Top level: DRAM row buffer latency model with config registers, front, queue and back end.
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        line_addr[25:0], is_write
//  rsp      out  valid/ready        latency[9:0], outcome[1:0], kind_count[31:0],
//                                   kind_delay_total[47:0]
//  apb      in   psel/penable       paddr[3:0], pwrite, pwdata[31:0] -> prdata, pready
//
// One access per cycle is accepted while the four-entry queue has room; the
// front end classifies it in the cycle of transfer against the bank row table.
// The accepted entry is written into the queue, then moves from the queue into
// the result register when the back end pops it; the back end retires one entry
// per cycle while the result register is empty or its result is being taken.
// rsp stalls back up through the queue to req.ready. Synchronous reset clears
// bank valid marks, statistics and registers; open rows need no reset.
module dram_row_buffer_latency import drbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  drbl_in_if.sink            req,
  drbl_out_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  drbl_cfg_t        cfg;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic             push;
  drbl_cmd_t        push_cmd;
  logic             pop;
  drbl_cmd_t        pop_cmd;
  drbl_q_stat_t     q_stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_policy <= 1'b0;
      cfg.base_delay  <= BASE_DELAY_RST;
      cfg.phase_delay <= PHASE_DELAY_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAGE_POLICY: cfg.page_policy <= pwdata[0];
        REG_BASE_DELAY:  cfg.base_delay  <= pwdata[DELAY_W-1:0];
        REG_PHASE_DELAY: cfg.phase_delay <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAGE_POLICY: prdata = PDATA_W'(cfg.page_policy);
      REG_BASE_DELAY:  prdata = PDATA_W'(cfg.base_delay);
      REG_PHASE_DELAY: prdata = PDATA_W'(cfg.phase_delay);
      default:         prdata = '0;
    endcase
  end

  drbl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .page_policy (cfg.page_policy),
    .req         (req),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  drbl_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  drbl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (pop_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_hit_latency: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.outcome == OUT_HIT && !cfg.page_policy) |->
      (rsp.latency == (LAT_W'(cfg.base_delay) + LAT_W'(cfg.phase_delay))))
    else $error("open page hit latency mismatch");
`endif

endmodule
